### hdl/pwmg_pkg.sv
package pwmg_pkg;

    // operation codes carried in tuser
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_MODE  = 2'd1;
    localparam logic [1:0] OP_PULSE = 2'd2;

    // mode codes
    localparam logic [2:0] MD_TRIGGER = 3'd0;
    localparam logic [2:0] MD_HIGH    = 3'd1;
    localparam logic [2:0] MD_LOW     = 3'd2;
    localparam logic [2:0] MD_TOGGLE  = 3'd3;
    localparam logic [2:0] MD_HIZ     = 3'd4;

    // drive state: bit 1 driven, bit 0 level
    localparam logic [1:0] DRV_HIZ  = 2'b00;
    localparam logic [1:0] DRV_LOW  = 2'b10;
    localparam logic [1:0] DRV_HIGH = 2'b11;

    localparam int          PULSE_CLAMP_MS_DEF = 2000;
    localparam int          PULSE_W            = 11;
    localparam int          COUNT_W            = 26;
    localparam int          PARAM_W            = 16;

    localparam logic [PULSE_W-1:0] TRIG_PULSE_MS = 11'd120;
    localparam logic [PARAM_W-1:0] DEF_PERIOD_S  = 16'd30;
    localparam logic [PARAM_W-1:0] DEF_HALF_MS   = 16'd500;
    localparam logic [PARAM_W-1:0] DEF_PULSE_MS  = 16'd120;
    localparam logic [COUNT_W-1:0] MS_PER_S      = 26'd1000;
    localparam logic [COUNT_W-1:0] RESET_COUNT   = 26'd30000;

endpackage

### hdl/pin_waveform_mode_generator.sv
// One-pin waveform generator: tri-state, hold high, hold low, periodic
// low trigger pulse and square-wave toggle, plus a one-shot low pulse.
// Input channel (s_axis): tuser carries the operation (tick of one ms,
// mode entry, one-shot pulse); tdata carries the requested mode and the
// 16-bit argument (trigger period in s, toggle half period in ms or pulse
// width in ms, 0 selects the default).
// Output channel (m_axis): one transaction per input transaction with the
// pin drive, level, current mode, pulse flag and latched parameter.
// The state update and the result register are written at the edge that
// accepts the input. Throughput is one transaction per cycle while the
// receiver does not stall; the path is a single constant multiply by 1000
// feeding the countdown reload.
// When the receiver stalls, the result is held and s_axis_tready drops
// only while a result waits and the receiver is not taking it.
// Reset enters trigger mode with a 30 s period, the pin tri-stated and
// no pulse being timed; the output channel is empty after reset.
// Mode and pulse commands that arrive while a pulse is timed are ignored.
module pin_waveform_mode_generator
    import pwmg_pkg::*;
#(
    parameter int PULSE_CLAMP_MS = PULSE_CLAMP_MS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,  // mode_request[2:0], argument[18:3], zero pad
    input  logic [1:0]  i_s_axis_tuser,  // operation[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata   // pin_driven[0], pin_level[1], mode_now[4:2],
                                         // pulse_active[5], param_now[21:6], zero pad
);

    localparam logic [PARAM_W-1:0] CLAMP = PARAM_W'(PULSE_CLAMP_MS);

    logic [2:0]         r_mode, n_mode;
    logic [PARAM_W-1:0] r_period, n_period;
    logic               r_tlevel, n_tlevel;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [PULSE_W-1:0] r_pulse, n_pulse;
    logic [1:0]         r_drive, n_drive;
    logic               r_out_valid;
    logic [23:0]        r_out_data;

    logic               accept;
    logic [1:0]         op;
    logic [2:0]         req;
    logic [PARAM_W-1:0] arg;
    logic [PARAM_W-1:0] arg_period, arg_half, arg_pulse, pulse_width, mul_src;
    logic [COUNT_W-1:0] period_ms;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign op              = i_s_axis_tuser;
    assign req             = i_s_axis_tdata[2:0];
    assign arg             = i_s_axis_tdata[18:3];

    assign arg_period  = (arg != '0) ? arg : DEF_PERIOD_S;
    assign arg_half    = (arg != '0) ? arg : DEF_HALF_MS;
    assign arg_pulse   = (arg != '0) ? arg : DEF_PULSE_MS;
    assign pulse_width = (arg_pulse > CLAMP) ? CLAMP : arg_pulse;

    // one shared seconds-to-ms multiplier
    assign mul_src   = (op == OP_MODE) ? arg_period : r_period;
    assign period_ms = {{(COUNT_W-PARAM_W){1'b0}}, mul_src} * MS_PER_S;

    always_comb begin
        n_mode   = r_mode;
        n_period = r_period;
        n_tlevel = r_tlevel;
        n_count  = r_count;
        n_pulse  = r_pulse;
        n_drive  = r_drive;
        case (op)
            OP_TICK: begin
                if (r_pulse != '0) begin
                    n_pulse = r_pulse - 1'b1;
                    if (r_pulse == PULSE_W'(1)) begin
                        n_drive = DRV_HIZ;
                        if (r_mode == MD_TRIGGER) begin
                            n_count = period_ms;
                        end
                    end
                end else if (r_mode == MD_TRIGGER || r_mode == MD_TOGGLE) begin
                    if (r_count > COUNT_W'(1)) begin
                        n_count = r_count - 1'b1;
                    end else if (r_mode == MD_TRIGGER) begin
                        n_count = '0;
                        n_pulse = TRIG_PULSE_MS;
                        n_drive = DRV_LOW;
                    end else begin
                        n_tlevel = !r_tlevel;
                        n_drive  = r_tlevel ? DRV_LOW : DRV_HIGH;
                        n_count  = {{(COUNT_W-PARAM_W){1'b0}}, r_period};
                    end
                end
            end
            OP_MODE: begin
                if (r_pulse == '0) begin
                    unique case (req)
                        MD_HIGH: begin
                            n_mode  = MD_HIGH;
                            n_drive = DRV_HIGH;
                            n_count = '0;
                        end
                        MD_LOW: begin
                            n_mode  = MD_LOW;
                            n_drive = DRV_LOW;
                            n_count = '0;
                        end
                        MD_TOGGLE: begin
                            n_mode   = MD_TOGGLE;
                            n_period = arg_half;
                            n_tlevel = 1'b1;
                            n_drive  = DRV_HIGH;
                            n_count  = {{(COUNT_W-PARAM_W){1'b0}}, arg_half};
                        end
                        MD_TRIGGER: begin
                            n_mode   = MD_TRIGGER;
                            n_period = arg_period;
                            n_drive  = DRV_HIZ;
                            n_count  = period_ms;
                        end
                        default: begin
                            n_mode  = MD_HIZ;
                            n_drive = DRV_HIZ;
                            n_count = '0;
                        end
                    endcase
                end
            end
            OP_PULSE: begin
                if (r_pulse == '0) begin
                    n_pulse = pulse_width[PULSE_W-1:0];
                    n_drive = (pulse_width[PULSE_W-1:0] != '0) ? DRV_LOW : DRV_HIZ;
                    n_mode  = MD_HIZ;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MD_TRIGGER;
            r_period    <= DEF_PERIOD_S;
            r_tlevel    <= 1'b1;
            r_count     <= RESET_COUNT;
            r_pulse     <= '0;
            r_drive     <= DRV_HIZ;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_mode   <= n_mode;
                r_period <= n_period;
                r_tlevel <= n_tlevel;
                r_count  <= n_count;
                r_pulse  <= n_pulse;
                r_drive  <= n_drive;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= {2'b00, n_period, (n_pulse != '0), n_mode,
                           n_drive[1] & n_drive[0], n_drive[1]};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // a timed pulse always holds the pin low
    a_pulse_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pulse != '0) |-> (r_drive == DRV_LOW))
        else $error("pin not driven low during pulse");

    // pulses only run in trigger mode or after a one-shot (hiz)
    a_pulse_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pulse != '0) |-> (r_mode == MD_TRIGGER || r_mode == MD_HIZ))
        else $error("pulse timed in wrong mode");

    // commands are dropped while a pulse is timed
    a_cmd_ignored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && op != OP_TICK && r_pulse != '0)
            |=> ($stable(r_mode) && $stable(r_period) && $stable(r_count)))
        else $error("command changed state during pulse");

    // toggle mode always drives the pin
    a_toggle_driven: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MD_TOGGLE) |-> r_drive[1])
        else $error("toggle mode left pin undriven");

endmodule
